FILE: hdl/afrb_pkg.sv
// ----------------------------------------------------------------------------
// afrb_pkg
// Shared types and constants of the audio frame ring buffer.
// ----------------------------------------------------------------------------
package afrb_pkg;

  // Operation codes as they arrive on the input channel.
  localparam logic [2:0] OP_WRITE     = 3'd0;
  localparam logic [2:0] OP_TICK      = 3'd1;
  localparam logic [2:0] OP_FLUSH     = 3'd2;
  localparam logic [2:0] OP_SET_SKIP  = 3'd3;
  localparam logic [2:0] OP_SET_PAUSE = 3'd4;

  // Write status codes reported with every result.
  localparam logic [1:0] WS_NONE     = 2'd0;
  localparam logic [1:0] WS_COMMIT   = 2'd1;
  localparam logic [1:0] WS_FULL     = 2'd2;
  localparam logic [1:0] WS_TOO_LONG = 2'd3;

  // Configuration register map.
  localparam logic REG_SILENCE_BYTES = 1'b0;
  localparam int unsigned SILENCE_W = 12;
  localparam logic [SILENCE_W-1:0] SILENCE_BYTES_RESET = 12'd1408;

  // Command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_TICK,
    CMD_FLUSH,
    CMD_SKIP,
    CMD_PAUSE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [31:0] playtime;
    logic [15:0] count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_out_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data_byte;
    logic        last;
    logic        silence;
    logic [1:0]  write_status;
    logic [4:0]  frames_buffered;
    logic [31:0] newest_playtime;
    logic [15:0] skip_left;
    logic [15:0] pause_left;
  } result_t;

endpackage

FILE: hdl/afrb_front.sv
// ----------------------------------------------------------------------------
// afrb_front
// Accepts input words and classifies the operation code into a command.
// ----------------------------------------------------------------------------
module afrb_front (
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_operation,
  input  logic [7:0]          in_data_byte,
  input  logic                in_frame_end,
  input  logic [31:0]         in_playtime,
  input  logic [15:0]         in_count,
  input  logic                full_i,
  output logic                push_o,
  output afrb_pkg::cmd_t      cmd_o
);

  assign busy   = full_i;
  assign push_o = start && !full_i;

  always_comb begin
    cmd_o.data_byte = in_data_byte;
    cmd_o.frame_end = in_frame_end;
    cmd_o.playtime  = in_playtime;
    cmd_o.count     = in_count;
    unique case (in_operation)
      afrb_pkg::OP_WRITE:     cmd_o.kind = afrb_pkg::CMD_WRITE;
      afrb_pkg::OP_TICK:      cmd_o.kind = afrb_pkg::CMD_TICK;
      afrb_pkg::OP_FLUSH:     cmd_o.kind = afrb_pkg::CMD_FLUSH;
      afrb_pkg::OP_SET_SKIP:  cmd_o.kind = afrb_pkg::CMD_SKIP;
      afrb_pkg::OP_SET_PAUSE: cmd_o.kind = afrb_pkg::CMD_PAUSE;
      default:                cmd_o.kind = afrb_pkg::CMD_NOP;
    endcase
  end

endmodule

FILE: hdl/afrb_cmd_queue.sv
// ----------------------------------------------------------------------------
// afrb_cmd_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module afrb_cmd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  afrb_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output afrb_pkg::queue_out_t q_o,
  output logic                 full_o
);

  afrb_pkg::cmd_t                       ent_r [afrb_pkg::QUEUE_DEPTH];
  logic [afrb_pkg::QUEUE_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [afrb_pkg::QUEUE_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [afrb_pkg::QUEUE_CNT_W-1:0]     cnt_r, cnt_nxt;

  assign full_o    = (cnt_r == afrb_pkg::QUEUE_CNT_W'(afrb_pkg::QUEUE_DEPTH));
  assign q_o.valid = (cnt_r != '0);
  assign q_o.cmd   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + afrb_pkg::QUEUE_CNT_W'(push_i) - afrb_pkg::QUEUE_CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      ent_r[wr_ptr_r] <= cmd_i;
    end
  end

endmodule

FILE: hdl/afrb_back.sv
// ----------------------------------------------------------------------------
// afrb_back
// Executes commands against the frame ring and produces one result each.
// ----------------------------------------------------------------------------
module afrb_back #(
  parameter int FRAME_SLOTS     = 32,
  parameter int FRAME_BYTES_MAX = 2048
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  afrb_pkg::queue_out_t                      q_i,
  output logic                                      pop_o,
  input  logic [$clog2(FRAME_BYTES_MAX+1)-1:0]      silence_len_i,
  output logic                                      res_strobe_o,
  output afrb_pkg::result_t                         res_o
);

  localparam int SW = $clog2(FRAME_SLOTS);
  localparam int OW = $clog2(FRAME_BYTES_MAX + 1);
  localparam int AW = $clog2(FRAME_SLOTS * FRAME_BYTES_MAX);

  typedef enum logic {BK_RUN, BK_FETCH} bk_state_t;
  typedef enum logic [1:0] {MODE_IDLE, MODE_FRAME, MODE_SILENCE} mode_t;

  bk_state_t         state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [SW-1:0]     rs_r, rs_nxt;
  logic [SW-1:0]     ws_r, ws_nxt;
  logic [OW-1:0]     in_len_r, in_len_nxt;
  logic              too_long_r, too_long_nxt;
  logic [OW-1:0]     off_r, off_nxt;
  logic [15:0]       skip_r, skip_nxt;
  logic [15:0]       pause_r, pause_nxt;
  logic [31:0]       newest_r, newest_nxt;
  logic              res_strobe_r, res_strobe_nxt;
  afrb_pkg::result_t res_r, res_nxt;

  logic [7:0]        byte_mem [FRAME_SLOTS*FRAME_BYTES_MAX];
  logic [OW-1:0]     len_mem  [FRAME_SLOTS];
  logic [7:0]        rd_byte_r;
  logic [OW-1:0]     rd_len_r;

  logic              byte_we, rd_en;
  logic [AW-1:0]     byte_waddr, byte_raddr;
  logic              len_we;

  logic              emit;
  logic              fill_valid, fill_last, fill_silence;
  logic [7:0]        fill_byte;
  logic [1:0]        status;
  logic [OW-1:0]     off_inc;
  logic [SW:0]       nb;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(FRAME_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] byte_addr(input logic [SW-1:0] s,
                                              input logic [OW-1:0] o);
    return AW'(s) * AW'(FRAME_BYTES_MAX) + AW'(o);
  endfunction

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    rs_nxt       = rs_r;
    ws_nxt       = ws_r;
    in_len_nxt   = in_len_r;
    too_long_nxt = too_long_r;
    off_nxt      = off_r;
    skip_nxt     = skip_r;
    pause_nxt    = pause_r;
    newest_nxt   = newest_r;
    pop_o        = 1'b0;
    emit         = 1'b0;
    fill_valid   = 1'b0;
    fill_byte    = '0;
    fill_last    = 1'b0;
    fill_silence = 1'b0;
    status       = afrb_pkg::WS_NONE;
    byte_we      = 1'b0;
    byte_waddr   = byte_addr(ws_r, in_len_r);
    rd_en        = 1'b0;
    byte_raddr   = '0;
    len_we       = 1'b0;
    off_inc      = '0;

    unique case (state_r)
      BK_RUN: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          emit  = 1'b1;
          unique case (q_i.cmd.kind)
            afrb_pkg::CMD_WRITE: begin
              if (!too_long_r) begin
                if (in_len_r < OW'(FRAME_BYTES_MAX)) begin
                  byte_we    = 1'b1;
                  in_len_nxt = in_len_r + 1'b1;
                end else begin
                  too_long_nxt = 1'b1;
                end
              end
              if (q_i.cmd.frame_end) begin
                if (too_long_nxt) begin
                  status = afrb_pkg::WS_TOO_LONG;
                end else if (next_slot(ws_r) == rs_r) begin
                  status = afrb_pkg::WS_FULL;
                end else begin
                  len_we     = 1'b1;
                  newest_nxt = q_i.cmd.playtime;
                  ws_nxt     = next_slot(ws_r);
                  status     = afrb_pkg::WS_COMMIT;
                end
                in_len_nxt   = '0;
                too_long_nxt = 1'b0;
              end
            end
            afrb_pkg::CMD_TICK: begin
              if (mode_r == MODE_IDLE) begin
                off_nxt = '0;
                if (skip_r != '0) begin
                  if (rs_r != ws_r) begin
                    rs_nxt   = next_slot(rs_r);
                    skip_nxt = skip_r - 1'b1;
                  end
                end else if (pause_r != '0) begin
                  pause_nxt = pause_r - 1'b1;
                  mode_nxt  = MODE_SILENCE;
                end else if (rs_r != ws_r) begin
                  mode_nxt = MODE_FRAME;
                end
              end
              if (mode_nxt == MODE_SILENCE) begin
                fill_valid   = 1'b1;
                fill_silence = 1'b1;
                off_inc      = off_nxt + 1'b1;
                if (off_inc >= silence_len_i) begin
                  fill_last = 1'b1;
                  mode_nxt  = MODE_IDLE;
                  off_nxt   = '0;
                end else begin
                  off_nxt = off_inc;
                end
              end else if (mode_nxt == MODE_FRAME) begin
                // The stored byte and length come back from registered reads in BK_FETCH.
                emit       = 1'b0;
                rd_en      = 1'b1;
                byte_raddr = byte_addr(rs_nxt, off_nxt);
                state_nxt  = BK_FETCH;
              end
            end
            afrb_pkg::CMD_FLUSH: begin
              rs_nxt       = '0;
              ws_nxt       = '0;
              in_len_nxt   = '0;
              too_long_nxt = 1'b0;
              mode_nxt     = MODE_IDLE;
              off_nxt      = '0;
            end
            afrb_pkg::CMD_SKIP:  skip_nxt  = q_i.cmd.count;
            afrb_pkg::CMD_PAUSE: pause_nxt = q_i.cmd.count;
            afrb_pkg::CMD_NOP: begin
            end
          endcase
        end
      end
      BK_FETCH: begin
        emit       = 1'b1;
        fill_valid = 1'b1;
        fill_byte  = rd_byte_r;
        off_inc    = off_r + 1'b1;
        if (off_inc >= rd_len_r) begin
          fill_last = 1'b1;
          rs_nxt    = next_slot(rs_r);
          mode_nxt  = MODE_IDLE;
          off_nxt   = '0;
        end else begin
          off_nxt = off_inc;
        end
        state_nxt = BK_RUN;
      end
    endcase

    if (ws_nxt >= rs_nxt) begin
      nb = {1'b0, ws_nxt} - {1'b0, rs_nxt};
    end else begin
      nb = {1'b0, ws_nxt} + (SW+1)'(FRAME_SLOTS) - {1'b0, rs_nxt};
    end

    res_strobe_nxt          = emit;
    res_nxt                 = res_r;
    if (emit) begin
      res_nxt.valid           = fill_valid;
      res_nxt.data_byte       = fill_byte;
      res_nxt.last            = fill_last;
      res_nxt.silence         = fill_silence;
      res_nxt.write_status    = status;
      res_nxt.frames_buffered = 5'(nb);
      res_nxt.newest_playtime = (nb != '0) ? newest_nxt : '0;
      res_nxt.skip_left       = skip_nxt;
      res_nxt.pause_left      = pause_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_RUN;
      mode_r       <= MODE_IDLE;
      rs_r         <= '0;
      ws_r         <= '0;
      in_len_r     <= '0;
      too_long_r   <= 1'b0;
      off_r        <= '0;
      skip_r       <= '0;
      pause_r      <= '0;
      res_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      rs_r         <= rs_nxt;
      ws_r         <= ws_nxt;
      in_len_r     <= in_len_nxt;
      too_long_r   <= too_long_nxt;
      off_r        <= off_nxt;
      skip_r       <= skip_nxt;
      pause_r      <= pause_nxt;
      res_strobe_r <= res_strobe_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    newest_r <= newest_nxt;
    res_r    <= res_nxt;
  end

  // Frame byte store and frame length store, both with registered reads.
  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= q_i.cmd.data_byte;
    end
    if (rd_en) begin
      rd_byte_r <= byte_mem[byte_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[ws_r] <= in_len_nxt == '0 ? in_len_r + 1'b1 : in_len_nxt;
    end
    if (rd_en) begin
      rd_len_r <= len_mem[rs_nxt];
    end
  end

  assign res_strobe_o = res_strobe_r;
  assign res_o        = res_r;

endmodule

FILE: hdl/audio_frame_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// audio_frame_ring_buffer_core
// Ring of frame slots with frame drop, skip and silence insertion.
// ----------------------------------------------------------------------------
// Usage: a command word is taken on the rising edge where start is high and
// busy is low. It carries an operation (write byte, output tick, flush, set
// skip count, set pause count) and its fields. Every command word yields
// exactly one result word, shown for a single cycle with out_strobe high; the
// receiver cannot stall, so results are simply presented and gone.
// A front stage decodes the operation and places it in a two-word queue;
// busy is high while that queue is full. The back stage executes one command
// per cycle, except an output tick that plays a stored frame byte, which
// passes through a fetch state because the byte store and length store have
// registered reads. Sustained rate is one word per cycle; a stored-frame tick
// holds the back stage in its fetch state, and later words wait in the queue.
// Reset (rst_n low, synchronous) empties the ring and clears the counts and
// the queue, and loads silence_bytes with 1408. The stores are not cleared:
// only committed frames are ever read back, so no clearing pass is needed.
// Configuration: silence_bytes is at byte address 0 of the APB-style port.
// The user must write it only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module audio_frame_ring_buffer_core #(
  parameter int FRAME_SLOTS     = 32,
  parameter int FRAME_BYTES_MAX = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic [31:0] in_playtime,
  input  logic [15:0] in_count,
  // Result channel.
  output logic        out_strobe,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_silence,
  output logic [1:0]  out_write_status,
  output logic [4:0]  out_frames_buffered,
  output logic [31:0] out_newest_playtime,
  output logic [15:0] out_skip_left,
  output logic [15:0] out_pause_left,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OW = $clog2(FRAME_BYTES_MAX + 1);
  localparam int CW = afrb_pkg::SILENCE_W + 1;

  logic [afrb_pkg::SILENCE_W-1:0] silence_r;
  logic [OW-1:0]                  silence_len;
  logic                           cfg_write;

  logic                           push;
  logic                           full;
  logic                           pop;
  afrb_pkg::cmd_t                 cmd;
  afrb_pkg::queue_out_t           q;
  logic                           res_strobe;
  afrb_pkg::result_t              res;

  // The register index is paddr[2]; only index zero exists.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == afrb_pkg::REG_SILENCE_BYTES) ? 32'(silence_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r <= afrb_pkg::SILENCE_BYTES_RESET;
    end else if (cfg_write && (paddr[2] == afrb_pkg::REG_SILENCE_BYTES)) begin
      silence_r <= pwdata[afrb_pkg::SILENCE_W-1:0];
    end
  end

  // A silence length of zero plays one byte; lengths above the slot size
  // saturate to the slot size.
  always_comb begin
    if (silence_r == '0) begin
      silence_len = OW'(1);
    end else if (CW'(silence_r) > CW'(FRAME_BYTES_MAX)) begin
      silence_len = OW'(FRAME_BYTES_MAX);
    end else begin
      silence_len = OW'(silence_r);
    end
  end

  afrb_front u_front (
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .in_playtime  (in_playtime),
    .in_count     (in_count),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  afrb_cmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .q_o    (q),
    .full_o (full)
  );

  afrb_back #(
    .FRAME_SLOTS     (FRAME_SLOTS),
    .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_i           (q),
    .pop_o         (pop),
    .silence_len_i (silence_len),
    .res_strobe_o  (res_strobe),
    .res_o         (res)
  );

  assign out_strobe          = res_strobe;
  assign out_valid           = res.valid;
  assign out_byte            = res.data_byte;
  assign out_last            = res.last;
  assign out_silence         = res.silence;
  assign out_write_status    = res.write_status;
  assign out_frames_buffered = res.frames_buffered;
  assign out_newest_playtime = res.newest_playtime;
  assign out_skip_left       = res.skip_left;
  assign out_pause_left      = res.pause_left;

endmodule
